// ----- src/deu_pkg.sv -----
// Shared types, constants and arctangent table for the direction to texture coordinate core.
`default_nettype none

package deu_pkg;

	// Default number of rotation steps in each angle chain.
	localparam int unsigned ANGLE_STAGES_DEF = 16;
	// Entries in the arctangent table; bounds the number of rotation steps.
	localparam int unsigned ATAN_ENTRIES = 24;

	// Width of the rotation datapath (signed) and of the binary angle (signed).
	localparam int unsigned CW = 28;
	localparam int unsigned AW = 32;

	// Square root: 48-bit radicand, one result bit per step.
	localparam int unsigned SQ_W = 48;
	localparam int unsigned SQRT_STEPS = SQ_W / 2;
	localparam int unsigned ROOT_W = SQRT_STEPS;

	// Binary angles: a full turn is 2^32.
	localparam logic [AW-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [AW-1:0] HALF_TURN = 32'h8000_0000;

	// atan(2^-i) as a binary angle.
	localparam logic [AW-1:0] ATAN_BAM [ATAN_ENTRIES] = '{
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
		32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
		32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
		32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
		32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
		32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
	};

	// Operands and accumulated angle handed from one rotation cell to the next.
	typedef struct packed {
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] b;
		logic signed [AW-1:0] ang;
	} cordic_t;

	// Remainder and partial root handed from one square root cell to the next.
	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] root;
	} sqrt_t;

	// Per-item flags that travel alongside the arithmetic.
	typedef struct packed {
		logic        pole;
		logic        xneg;
		logic        zneg;
		logic        ypos;
		logic        yneg;
		logic [15:0] ay;
	} side_t;

endpackage

`default_nettype wire

// ----- src/deu_sqrt_cell.sv -----
// One registered step of the digit-by-digit integer square root.
`default_nettype none

module deu_sqrt_cell
	import deu_pkg::*;
#(
	parameter int unsigned STEP = 0
) (
	input  logic  clk,
	input  sqrt_t din,
	output sqrt_t dout
);

	// Trial bit of this step: a power of four, falling by a factor of four each step.
	localparam logic [SQ_W-1:0] TRIAL = SQ_W'(1) << (SQ_W - 2 - 2 * STEP);

	logic [SQ_W-1:0] cand;
	sqrt_t           nxt;

	// Subtract the candidate when it fits and set the corresponding root bit.
	always_comb begin
		cand = din.root + TRIAL;
		if (din.rem >= cand) begin
			nxt.rem = din.rem - cand;
			nxt.root = (din.root >> 1) + TRIAL;
		end else begin
			nxt.rem = din.rem;
			nxt.root = din.root >> 1;
		end
	end

	// Hand the result to the next cell.
	always_ff @(posedge clk) begin
		dout <= nxt;
	end

endmodule

`default_nettype wire

// ----- src/deu_cordic_cell.sv -----
// One registered vectoring rotation step of the angle chains.
`default_nettype none

module deu_cordic_cell
	import deu_pkg::*;
#(
	parameter int unsigned STAGE = 0
) (
	input  logic    clk,
	input  cordic_t din,
	output cordic_t dout
);

	localparam logic signed [AW-1:0] STEP_ANG = signed'(ATAN_BAM[STAGE]);

	logic signed [CW-1:0] a_in;
	logic signed [CW-1:0] b_in;
	logic signed [CW-1:0] a_sh;
	logic signed [CW-1:0] b_sh;
	logic                 b_pos;
	cordic_t              nxt;

	// Rotate towards the a axis, by the sign of b, and track the angle turned.
	always_comb begin
		a_in = din.a;
		b_in = din.b;
		a_sh = a_in >>> STAGE;
		b_sh = b_in >>> STAGE;
		b_pos = !b_in[CW-1] && (b_in != '0);
		if (b_pos) begin
			nxt.a = a_in + b_sh;
			nxt.b = b_in - a_sh;
			nxt.ang = din.ang + STEP_ANG;
		end else begin
			nxt.a = a_in - b_sh;
			nxt.b = b_in + a_sh;
			nxt.ang = din.ang - STEP_ANG;
		end
	end

	// Hand the rotated vector to the next cell.
	always_ff @(posedge clk) begin
		dout <= nxt;
	end

endmodule

`default_nettype wire

// ----- src/direction_to_equirect_uv_core.sv -----
// Top level: equirectangular texture coordinate of a view-ray direction.
// Takes one item in every clock cycle; busy is never raised.
// done rises once an item has passed the chain of three front stages, 24 square root
// cells and ANGLE_STAGES elevation rotation cells; the horizontal angle runs alongside.
// Reset clears the valid line, so no result appears until items are fed in.
`default_nettype none

module direction_to_equirect_uv_core
	import deu_pkg::*;
#(
	parameter int unsigned ANGLE_STAGES = ANGLE_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	output logic               done,
	output logic        [15:0] tex_u,
	output logic        [15:0] tex_v
);

	// Flag line spans from the third stage to the end of the elevation chain.
	localparam int unsigned SIDE_LEN = SQRT_STEPS + 1 + ANGLE_STAGES;
	localparam int unsigned HEND = ANGLE_STAGES;
	localparam int unsigned EEND = SIDE_LEN - 1;

	// Front stage registers.
	logic               vld_s1;
	logic               vld_s2;
	logic signed [15:0] x_s1;
	logic signed [15:0] y_s1;
	logic signed [15:0] z_s1;
	logic        [30:0] sqx_s2;
	logic        [30:0] sqz_s2;
	logic        [15:0] ax_s2;
	logic        [15:0] az_s2;
	side_t              side_s2;
	logic        [31:0] h2_s3;
	logic        [15:0] ax_s3;
	logic        [15:0] az_s3;

	// Lines that run alongside the cell chains.
	logic  [SIDE_LEN-1:0] vld_q;
	side_t                side_q [SIDE_LEN];
	logic  [15:0]         u_q [SQRT_STEPS];

	// Links between cells.
	sqrt_t   sq_io [SQRT_STEPS + 1];
	cordic_t hc_io [ANGLE_STAGES + 1];
	cordic_t ec_io [ANGLE_STAGES + 1];

	// Output registers.
	logic        done_q;
	logic [15:0] tex_u_q;
	logic [15:0] tex_v_q;

	// Combinational results at the ends of the chains.
	logic signed [15:0] x_neg;
	logic signed [15:0] z_neg;
	logic signed [31:0] prod_x;
	logic signed [31:0] prod_z;
	logic        [30:0] phi;
	logic        [31:0] abam;
	logic        [32:0] q_sum;
	logic        [16:0] q_val;
	logic        [16:0] u_wide;
	logic        [15:0] u_nxt;
	logic        [30:0] ebam;
	logic        [31:0] r_sum;
	logic        [16:0] r_val;
	logic        [16:0] v_wide;
	logic        [15:0] v_nxt;
	side_t              hs_side;
	side_t              es_side;

	assign busy = 1'b0;

	// Valid line; every item is accepted since busy stays low.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_q <= '0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_q <= {vld_q[SIDE_LEN-2:0], vld_s2};
			done_q <= vld_q[EEND];
		end
	end

	// Squares and negations of the components.
	always_comb begin
		x_neg = -x_s1;
		z_neg = -z_s1;
		prod_x = 32'(x_s1) * 32'(x_s1);
		prod_z = 32'(z_s1) * 32'(z_s1);
	end

	// Front stages: capture, square, then sum into the radicand.
	always_ff @(posedge clk) begin
		x_s1 <= dir_x;
		y_s1 <= dir_y;
		z_s1 <= dir_z;
		sqx_s2 <= prod_x[30:0];
		sqz_s2 <= prod_z[30:0];
		ax_s2 <= x_s1[15] ? x_neg : x_s1;
		az_s2 <= z_s1[15] ? z_neg : z_s1;
		side_s2.pole <= (x_s1 == '0) && (z_s1 == '0);
		side_s2.xneg <= x_s1[15];
		side_s2.zneg <= z_s1[15];
		side_s2.ypos <= !y_s1[15] && (y_s1 != '0);
		side_s2.yneg <= y_s1[15];
		side_s2.ay <= y_s1[15] ? 16'(-y_s1) : y_s1;
		h2_s3 <= 32'(sqx_s2) + 32'(sqz_s2);
		ax_s3 <= ax_s2;
		az_s3 <= az_s2;
	end

	// Flag line and the line that holds u until v is ready.
	always_ff @(posedge clk) begin
		side_q[0] <= side_s2;
		for (int i = 1; i < SIDE_LEN; i++) begin
			side_q[i] <= side_q[i-1];
		end
		u_q[0] <= u_nxt;
		for (int j = 1; j < SQRT_STEPS; j++) begin
			u_q[j] <= u_q[j-1];
		end
	end

	// Square root chain on (x^2 + z^2) * 65536.
	assign sq_io[0].rem = {h2_s3, 16'h0000};
	assign sq_io[0].root = '0;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		deu_sqrt_cell #(
			.STEP(k)
		) u_cell (
			.clk (clk),
			.din (sq_io[k]),
			.dout(sq_io[k+1])
		);
	end

	// Horizontal angle chain on (|x|, |z|), running beside the square root.
	assign hc_io[0].a = signed'({{(CW-24){1'b0}}, ax_s3, 8'h00});
	assign hc_io[0].b = signed'({{(CW-24){1'b0}}, az_s3, 8'h00});
	assign hc_io[0].ang = '0;

	// Elevation angle chain on (|h|, |y|).
	assign ec_io[0].a = signed'({{(CW-ROOT_W){1'b0}}, sq_io[SQRT_STEPS].root[ROOT_W-1:0]});
	assign ec_io[0].b = signed'({{(CW-24){1'b0}}, side_q[SQRT_STEPS].ay, 8'h00});
	assign ec_io[0].ang = '0;

	for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_angle
		deu_cordic_cell #(
			.STAGE(i)
		) u_hcell (
			.clk (clk),
			.din (hc_io[i]),
			.dout(hc_io[i+1])
		);
		deu_cordic_cell #(
			.STAGE(i)
		) u_ecell (
			.clk (clk),
			.din (ec_io[i]),
			.dout(ec_io[i+1])
		);
	end

	// Horizontal coordinate from the clamped angle, mirrored by the signs of x and z.
	always_comb begin
		hs_side = side_q[HEND];
		if (hc_io[ANGLE_STAGES].ang[AW-1]) begin
			phi = '0;
		end else if (hc_io[ANGLE_STAGES].ang > signed'(QUARTER_TURN)) begin
			phi = QUARTER_TURN[30:0];
		end else begin
			phi = hc_io[ANGLE_STAGES].ang[30:0];
		end
		abam = hs_side.xneg ? (HALF_TURN - 32'(phi)) : 32'(phi);
		q_sum = 33'(abam) + 33'd32768;
		q_val = q_sum[32:16];
		u_wide = 17'd65536 - q_val;
		if (hs_side.pole) begin
			u_nxt = '0;
		end else if (hs_side.zneg) begin
			u_nxt = q_val[15:0];
		end else if (u_wide[16]) begin
			u_nxt = 16'hFFFF;
		end else begin
			u_nxt = u_wide[15:0];
		end
	end

	// Vertical coordinate from the clamped elevation, above or below the horizon.
	always_comb begin
		es_side = side_q[EEND];
		if (ec_io[ANGLE_STAGES].ang[AW-1]) begin
			ebam = '0;
		end else if (ec_io[ANGLE_STAGES].ang > signed'(QUARTER_TURN)) begin
			ebam = QUARTER_TURN[30:0];
		end else begin
			ebam = ec_io[ANGLE_STAGES].ang[30:0];
		end
		r_sum = 32'(ebam) + 32'd16384;
		r_val = r_sum[31:15];
		v_wide = 17'd32768 + r_val;
		if (es_side.pole) begin
			if (es_side.ypos) begin
				v_nxt = '0;
			end else if (es_side.yneg) begin
				v_nxt = 16'hFFFF;
			end else begin
				v_nxt = 16'h8000;
			end
		end else if (es_side.ypos) begin
			v_nxt = 16'(17'd32768 - r_val);
		end else if (v_wide[16]) begin
			v_nxt = 16'hFFFF;
		end else begin
			v_nxt = v_wide[15:0];
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		tex_u_q <= u_q[SQRT_STEPS-1];
		tex_v_q <= v_nxt;
	end

	assign done = done_q;
	assign tex_u = tex_u_q;
	assign tex_v = tex_v_q;

	// The square root of a 48-bit radicand never needs more than 24 bits.
	a_root_width: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[SQRT_STEPS] |-> (sq_io[SQRT_STEPS].root[SQ_W-1:ROOT_W] == '0))
		else $error("square root overflowed its result width");

	// A direction at a pole gives u of zero.
	a_pole_u: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[EEND] && es_side.pole) |=> (done && (tex_u == '0)))
		else $error("pole item did not give u of zero");

	// Upward directions map to the upper half of the map.
	a_upper_v: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[EEND] && es_side.ypos) |=> (tex_v <= 16'h8000))
		else $error("upward item landed below the horizon");

	// Non-upward directions map to the lower half of the map.
	a_lower_v: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[EEND] && !es_side.ypos) |=> (tex_v >= 16'h8000))
		else $error("downward item landed above the horizon");

	// With negative z the horizontal angle stays within half a turn.
	a_half_u: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[HEND] && hs_side.zneg) |-> (u_nxt <= 16'h8000))
		else $error("horizontal coordinate out of range for negative z");

endmodule

`default_nettype wire

// ----- test/direction_to_equirect_uv_core_test.sv -----
// Testbench for the direction to equirectangular texture coordinate core.
module direction_to_equirect_uv_core_test;
	import deu_pkg::*;

	// Expected texture coordinate of one ray.
	typedef struct packed {
		logic [15:0] u;
		logic [15:0] v;
	} uv_t;

	// One directed ray; where known is set, the coordinate is typed in here.
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               known;
		uv_t                uv;
	} ray_row_t;

	localparam int DIRECTED_RAYS = 22;
	localparam int RANDOM_RAYS = 900;
	localparam int IDLE_PERCENT = 27;
	localparam int CALM_FIRST = 250;
	localparam int CALM_LAST = 550;
	localparam int DRAIN_CYCLES = ANGLE_STAGES_DEF + 40;
	localparam int STEP_LIMIT = 24;

	// Arctangent of 2^-i as a binary angle, a full turn being 2^32.
	localparam longint ATAN_STEP [24] = '{
		64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4,
		64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
		64'h0028_BE53, 64'h0014_5F2F, 64'h000A_2F98, 64'h0005_17CC,
		64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2F9, 64'h0000_517C,
		64'h0000_28BE, 64'h0000_145F, 64'h0000_0A2F, 64'h0000_0517,
		64'h0000_028B, 64'h0000_0145, 64'h0000_00A2, 64'h0000_0051
	};

	// Directed rays: poles and the zero vector are typed in, the rest predicted.
	localparam ray_row_t RAY_TABLE [DIRECTED_RAYS] = '{
		'{16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'd0, 16'd32768}},
		'{16'sd0, 16'sd1, 16'sd0, 1'b1, '{16'd0, 16'd0}},
		'{16'sd0, -16'sd1, 16'sd0, 1'b1, '{16'd0, 16'd65535}},
		'{16'sd0, 16'sd32767, 16'sd0, 1'b1, '{16'd0, 16'd0}},
		'{16'sd0, -16'sd32768, 16'sd0, 1'b1, '{16'd0, 16'd65535}},
		'{16'sd32767, 16'sd0, 16'sd0, 1'b0, '{16'd0, 16'd0}},
		'{-16'sd32768, 16'sd0, 16'sd0, 1'b0, '{16'd0, 16'd0}},
		'{16'sd0, 16'sd0, 16'sd32767, 1'b0, '{16'd0, 16'd0}},
		'{16'sd0, 16'sd0, -16'sd32768, 1'b0, '{16'd0, 16'd0}},
		'{16'sd1, 16'sd0, 16'sd0, 1'b0, '{16'd0, 16'd0}},
		'{-16'sd1, 16'sd0, 16'sd0, 1'b0, '{16'd0, 16'd0}},
		'{16'sd0, 16'sd0, 16'sd1, 1'b0, '{16'd0, 16'd0}},
		'{16'sd0, 16'sd0, -16'sd1, 1'b0, '{16'd0, 16'd0}},
		'{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '{16'd0, 16'd0}},
		'{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '{16'd0, 16'd0}},
		'{16'sd32767, -16'sd32768, -16'sd32768, 1'b0, '{16'd0, 16'd0}},
		'{-16'sd32768, 16'sd32767, 16'sd32767, 1'b0, '{16'd0, 16'd0}},
		'{16'sd23170, 16'sd0, -16'sd23170, 1'b0, '{16'd0, 16'd0}},
		'{-16'sd23170, 16'sd23170, 16'sd23170, 1'b0, '{16'd0, 16'd0}},
		'{16'sd32767, 16'sd1, -16'sd1, 1'b0, '{16'd0, 16'd0}},
		'{-16'sd1, -16'sd32768, 16'sd1, 1'b0, '{16'd0, 16'd0}},
		'{16'sd18918, 16'sd18918, 16'sd18918, 1'b0, '{16'd0, 16'd0}}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;
	logic               done;
	logic        [15:0] tex_u;
	logic        [15:0] tex_v;

	uv_t pending_uv [$];
	int  mismatch_count = 0;
	int  rays_sent = 0;

	direction_to_equirect_uv_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.dir_x  (dir_x),
		.dir_y  (dir_y),
		.dir_z  (dir_z),
		.done   (done),
		.tex_u  (tex_u),
		.tex_v  (tex_v)
	);

	// Free-running clock, period four.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Vectoring rotation: atan2(b, a) for a, b >= 0, clamped to a quarter turn.
	function automatic longint cordic_angle(longint a, longint b);
		longint ang;
		longint na;
		longint nb;
		ang = 0;
		for (int i = 0; i < ANGLE_STAGES_DEF && i < STEP_LIMIT; i++) begin
			if (b > 0) begin
				na = a + (b >>> i);
				nb = b - (a >>> i);
				ang += ATAN_STEP[i];
			end else begin
				na = a - (b >>> i);
				nb = b + (a >>> i);
				ang -= ATAN_STEP[i];
			end
			a = na;
			b = nb;
		end
		if (ang < 0)
			ang = 0;
		if (ang > 64'sh4000_0000)
			ang = 64'sh4000_0000;
		return ang;
	endfunction

	// Exact integer square root, rounded down.
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned probe;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > n)
			probe >>= 2;
		while (probe != 0) begin
			if (n >= root + probe) begin
				n -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	// Texture coordinate that a ray direction should produce.
	function automatic uv_t uv_of_direction(logic signed [15:0] x, logic signed [15:0] y,
		logic signed [15:0] z);
		longint sx;
		longint sy;
		longint sz;
		longint h2;
		longint phi;
		longint abam;
		longint q;
		longint ebam;
		longint r;
		longint uu;
		longint vv;
		sx = longint'(x);
		sy = longint'(y);
		sz = longint'(z);
		h2 = sx * sx + sz * sz;
		if (h2 == 0) begin
			// Pole or zero vector: no horizontal direction at all.
			uu = 0;
			vv = (sy > 0) ? 0 : ((sy < 0) ? 65535 : 32768);
		end else begin
			phi = cordic_angle((sx < 0 ? -sx : sx) << 8, (sz < 0 ? -sz : sz) << 8);
			abam = (sx < 0) ? ((64'sd1 << 31) - phi) : phi;
			q = (abam + 32768) >>> 16;
			ebam = cordic_angle(longint'(int_sqrt(longint'(h2) << 16)),
				(sy < 0 ? -sy : sy) << 8);
			r = (ebam + 16384) >>> 15;
			if (sz < 0) begin
				uu = q;
			end else begin
				uu = 65536 - q;
				if (uu > 65535)
					uu = 65535;
			end
			if (sy > 0) begin
				vv = 32768 - r;
				if (vv < 0)
					vv = 0;
			end else begin
				vv = 32768 + r;
				if (vv > 65535)
					vv = 65535;
			end
		end
		return '{u: uu[15:0], v: vv[15:0]};
	endfunction

	// Offer one ray, after idle cycles drawn one by one outside the calm window, and note its coordinate once taken.
	task automatic send_ray(logic signed [15:0] x, logic signed [15:0] y,
		logic signed [15:0] z, logic known, uv_t typed_uv);
		uv_t want;
		while ((rays_sent < CALM_FIRST || rays_sent >= CALM_LAST)
			&& $urandom_range(0, 99) < IDLE_PERCENT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		want = known ? typed_uv : uv_of_direction(x, y, z);
		start <= 1'b1;
		dir_x <= x;
		dir_y <= y;
		dir_z <= z;
		do
			@(posedge clk);
		while (busy);
		pending_uv.push_back(want);
		rays_sent++;
	endtask

	// Compare every result with the oldest coordinate still awaited.
	always @(posedge clk) begin
		uv_t want;
		if (done) begin
			if (pending_uv.size() == 0) begin
				$display("%0t: unexpected result u=%0d v=%0d", $time, tex_u, tex_v);
				mismatch_count++;
			end else begin
				want = pending_uv.pop_front();
				if (tex_u !== want.u) begin
					$display("%0t: tex_u expected %0d, got %0d", $time, want.u, tex_u);
					mismatch_count++;
				end
				if (tex_v !== want.v) begin
					$display("%0t: tex_v expected %0d, got %0d", $time, want.v, tex_v);
					mismatch_count++;
				end
			end
		end
	end

	// Reset, directed rays, random rays, then drain and report.
	initial begin
		int                 kind;
		int                 pick;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic signed [15:0] rz;
		logic signed [15:0] edge_vals [6];
		edge_vals = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
		arst_n = 1'b0;
		start = 1'b0;
		dir_x = '0;
		dir_y = '0;
		dir_z = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part.
		foreach (RAY_TABLE[i])
			send_ray(RAY_TABLE[i].x, RAY_TABLE[i].y, RAY_TABLE[i].z,
				RAY_TABLE[i].known, RAY_TABLE[i].uv);

		// Random part: mostly full-range rays, with short vectors, zeroed x or z, poles, edge values and low y mixed in.
		for (int n = 0; n < RANDOM_RAYS; n++) begin
			kind = $urandom_range(0, 9);
			rx = 16'($urandom());
			ry = 16'($urandom());
			rz = 16'($urandom());
			case (kind)
				5: begin
					rx = 16'($urandom_range(0, 128) - 64);
					ry = 16'($urandom_range(0, 128) - 64);
					rz = 16'($urandom_range(0, 128) - 64);
				end
				6: begin
					if ($urandom_range(0, 1))
						rx = '0;
					else
						rz = '0;
				end
				7: begin
					rx = '0;
					rz = '0;
					if ($urandom_range(0, 7) == 0)
						ry = '0;
				end
				8: begin
					pick = $urandom_range(0, 5);
					rx = edge_vals[pick];
					pick = $urandom_range(0, 5);
					ry = edge_vals[pick];
					pick = $urandom_range(0, 5);
					rz = edge_vals[pick];
				end
				9: ry = 16'($urandom_range(0, 512) - 256);
				default: ;
			endcase
			send_ray(rx, ry, rz, 1'b0, '0);
		end
		start <= 1'b0;

		// Wait for every outstanding coordinate, then watch for stray results.
		while (pending_uv.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#400000;
		$display("Some tests failed");
		$finish;
	end

endmodule
